### hdl/level_stream_to_validity_and_records_unit_assert.svh
// Assertion macros for the level stream to validity and records unit.
`ifndef LEVEL_STREAM_TO_VALIDITY_AND_RECORDS_UNIT_ASSERT_SVH
`define LEVEL_STREAM_TO_VALIDITY_AND_RECORDS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LSVR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsvr: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LSVR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsvr: next-cycle check failed");

`endif

### hdl/lsvr_pkg.sv
// Shared constants, types and helpers for the level stream to validity unit.
package lsvr_pkg;

    localparam int BITMAP_BYTES  = 8192;
    localparam int COUNT_WIDTH   = 16;
    localparam int BITS_PER_BYTE = 8;
    localparam int LEVEL_W       = 8;
    localparam int BYTE_IDX_W    = $clog2(BITMAP_BYTES);
    localparam int BIT_POS_W     = $clog2(BITS_PER_BYTE);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEF_LEVEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REP_LEVEL = CFG_IDX_W'(1);

    typedef logic [COUNT_WIDTH-1:0]   count_t;
    typedef logic [LEVEL_W-1:0]       level_t;
    typedef logic [BYTE_IDX_W-1:0]    byte_idx_t;
    typedef logic [BIT_POS_W-1:0]     bit_pos_t;
    typedef logic [BITS_PER_BYTE-1:0] bmap_byte_t;

    typedef struct packed {
        level_t def_level;
        level_t rep_level;
        logic   last_level;
    } level_item_t;

    typedef struct packed {
        logic       byte_out_valid;
        logic       byte_complete;
        bmap_byte_t validity_byte;
        byte_idx_t  byte_index;
        count_t     record_count;
        count_t     value_count;
        count_t     null_slot_count;
        count_t     slot_count;
        logic       record_start;
        logic       level_error;
    } result_item_t;

    typedef struct packed {
        level_t max_def_level;
        level_t max_rep_level;
    } cfg_t;

    // Saturating increment
    function automatic count_t sat_inc(count_t c, logic en);
        if (en && (c != '1))
            return c + COUNT_WIDTH'(1);
        return c;
    endfunction

endpackage

### hdl/lsvr_if.sv
// Valid/ready channel interfaces for level items and result items.
interface lsvr_level_if
    import lsvr_pkg::*;
();
    logic        valid;
    logic        ready;
    level_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lsvr_result_if
    import lsvr_pkg::*;
();
    logic         valid;
    logic         ready;
    result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/lsvr_cfg.sv
// Configuration register file: maximum definition and repetition levels.
module lsvr_cfg
    import lsvr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_MAX_DEF_LEVEL: cfg_next.max_def_level = wr_data[LEVEL_W-1:0];
                CFG_MAX_REP_LEVEL: cfg_next.max_rep_level = wr_data[LEVEL_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_def_level <= LEVEL_W'(1);
            cfg_reg.max_rep_level <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/lsvr_in_reg.sv
// Input register stage: holds one level item until the step logic takes it.
module lsvr_in_reg
    import lsvr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lsvr_level_if.sink   levels,
    input  logic         adv,
    output logic         item_valid,
    output level_item_t  item
);

    logic        valid_reg;
    logic        valid_next;
    level_item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign levels.ready = !valid_reg || adv;

    always_comb
    begin
        valid_next = valid_reg;
        if (levels.ready)
            valid_next = levels.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (levels.ready && levels.valid)
            item_reg <= levels.data;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hdl/lsvr_step.sv
// Per-item step: bitmap packing, byte emit/flush and saturating batch counts.
module lsvr_step
    import lsvr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  level_item_t   item,
    input  logic          adv,
    output result_item_t  res
);

    bmap_byte_t partial_reg, partial_next;
    bit_pos_t   bit_pos_reg, bit_pos_next;
    byte_idx_t  byte_pos_reg, byte_pos_next;
    count_t     records_reg, records_next;
    count_t     values_reg, values_next;
    count_t     nulls_reg, nulls_next;
    count_t     slots_reg, slots_next;
    logic       rec_start_reg, rec_start_next;

    logic       repeated;
    logic       is_max;
    logic       is_null;
    logic       write_bit;
    logic       level_err;
    logic       rec_inc;
    logic       byte_full;
    logic       flush;
    bmap_byte_t merged;
    bit_pos_t   bit_pos_after;
    count_t     records_inc, values_inc, nulls_inc, slots_inc;

    // Level classification
    always_comb
    begin
        repeated  = (cfg.max_rep_level != '0);
        is_max    = (item.def_level == cfg.max_def_level);
        if (repeated)
            is_null = (cfg.max_def_level != '0)
                   && (item.def_level == (cfg.max_def_level - LEVEL_W'(1)));
        else
            is_null = (item.def_level < cfg.max_def_level);
        write_bit = is_max || is_null;
        level_err = !repeated && (item.def_level > cfg.max_def_level);
        rec_inc   = !repeated || (item.rep_level == '0);
    end

    // Bit packing, LSB first
    always_comb
    begin
        merged        = partial_reg | (BITS_PER_BYTE'(is_max) << bit_pos_reg);
        byte_full     = write_bit && (bit_pos_reg == '1);
        bit_pos_after = byte_full ? '0 : bit_pos_reg + BIT_POS_W'(write_bit);
        flush         = item.last_level && !byte_full && (bit_pos_after != '0);
        partial_next  = byte_full ? '0 : merged;
        bit_pos_next  = bit_pos_after;
        if (byte_full)
            byte_pos_next = (byte_pos_reg == BYTE_IDX_W'(BITMAP_BYTES - 1))
                          ? '0 : byte_pos_reg + BYTE_IDX_W'(1);
        else
            byte_pos_next = byte_pos_reg;
        rec_start_next = repeated ? (item.rep_level == '0) : rec_start_reg;
    end

    // Batch counts; cleared after the last level is reported
    always_comb
    begin
        records_inc  = sat_inc(records_reg, rec_inc);
        values_inc   = sat_inc(values_reg, is_max);
        nulls_inc    = sat_inc(nulls_reg, is_null);
        slots_inc    = sat_inc(slots_reg, write_bit);
        records_next = item.last_level ? '0 : records_inc;
        values_next  = item.last_level ? '0 : values_inc;
        nulls_next   = item.last_level ? '0 : nulls_inc;
        slots_next   = item.last_level ? '0 : slots_inc;
    end

    // Result item
    always_comb
    begin
        res.byte_out_valid  = byte_full || flush;
        res.byte_complete   = byte_full;
        res.validity_byte   = (byte_full || flush) ? merged : '0;
        res.byte_index      = (byte_full || flush) ? byte_pos_reg : '0;
        res.record_count    = records_inc;
        res.value_count     = values_inc;
        res.null_slot_count = nulls_inc;
        res.slot_count      = slots_inc;
        res.record_start    = repeated && rec_start_next;
        res.level_error     = level_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            bit_pos_reg   <= '0;
            byte_pos_reg  <= '0;
            records_reg   <= '0;
            values_reg    <= '0;
            nulls_reg     <= '0;
            slots_reg     <= '0;
            rec_start_reg <= 1'b0;
        end
        else if (adv)
        begin
            partial_reg   <= partial_next;
            bit_pos_reg   <= bit_pos_next;
            byte_pos_reg  <= byte_pos_next;
            records_reg   <= records_next;
            values_reg    <= values_next;
            nulls_reg     <= nulls_next;
            slots_reg     <= slots_next;
            rec_start_reg <= rec_start_next;
        end
    end

endmodule

### hdl/lsvr_out_reg.sv
// Output register stage: holds one result item until the sink takes it.
module lsvr_out_reg
    import lsvr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  result_item_t  res,
    output logic          can_load,
    lsvr_result_if.source results
);

    logic         valid_reg;
    logic         valid_next;
    result_item_t data_reg;

    // Room when empty or when the held item leaves this cycle
    assign can_load = !valid_reg || results.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (results.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign results.valid = valid_reg;
    assign results.data  = data_reg;

endmodule

### hdl/level_stream_to_validity_and_records_unit.sv
// An accepted item passes through two register stages, the input register and then the output register.
// Throughput: one item per cycle while the sink takes results, set by the combinational step between the two registers.
// The input register takes a new item while a finished result waits at the output, if it is itself empty.
// Reset (rst_n low, async): bitmap position, batch counts and valids clear;
// max_def_level returns to 1 and max_rep_level to 0.
module level_stream_to_validity_and_records_unit
    import lsvr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    lsvr_level_if.sink            levels,
    lsvr_result_if.source         results,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    `include "level_stream_to_validity_and_records_unit_assert.svh"

    cfg_t         cfg;
    logic         item_valid;
    level_item_t  item;
    logic         can_load;
    logic         adv;
    result_item_t res;

    // Held item moves into the output register when there is room
    assign adv = item_valid && can_load;

    lsvr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    lsvr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .levels     (levels),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item)
    );

    lsvr_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .item  (item),
        .adv   (adv),
        .res   (res)
    );

    lsvr_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv),
        .res      (res),
        .can_load (can_load),
        .results  (results)
    );

    // Full pipe with a stalled sink takes no new item
    `LSVR_ASSERT_SAME(a_full_stall, item_valid && results.valid && !results.ready, !levels.ready)
    // An item that moves on is presented next cycle
    `LSVR_ASSERT_NEXT(a_adv_shows, adv, results.valid)
    // A partial flush never carries the top bit
    `LSVR_ASSERT_SAME(a_flush_partial, results.valid && results.data.byte_out_valid && !results.data.byte_complete, !results.data.validity_byte[BITS_PER_BYTE-1])
    // A filled byte means at least one slot was written this batch
    `LSVR_ASSERT_SAME(a_full_slots, results.valid && results.data.byte_complete, results.data.byte_out_valid && (results.data.slot_count != '0))

endmodule
